/* rtl/utf8s_pkg.sv */
// utf8s_pkg: shared types, constants and the lead byte classifier
// for the utf8 sequence segmenter; no dependencies
package utf8s_pkg;

  localparam int unsigned UTF8S_JOB_DEPTH = 4;

  localparam logic [7:0] ASCII_MAX   = 8'h7F;
  localparam logic [7:0] CONT_MIN    = 8'h80;
  localparam logic [7:0] CONT_MAX    = 8'hBF;
  localparam logic [7:0] LEAD2_MIN   = 8'hC2;
  localparam logic [7:0] LEAD2_MAX   = 8'hDF;
  localparam logic [7:0] LEAD3_MIN   = 8'hE0;
  localparam logic [7:0] LEAD3_MAX   = 8'hEF;
  localparam logic [7:0] LEAD4_MIN   = 8'hF0;
  localparam logic [7:0] LEAD4_MAX   = 8'hF4;
  localparam logic [7:0] LEAD_E0     = 8'hE0;
  localparam logic [7:0] LEAD_ED     = 8'hED;
  localparam logic [7:0] LEAD_F0     = 8'hF0;
  localparam logic [7:0] LEAD_F4     = 8'hF4;
  localparam logic [7:0] E0_SEC_MIN  = 8'hA0;
  localparam logic [7:0] ED_SEC_MAX  = 8'h9F;
  localparam logic [7:0] F0_SEC_MIN  = 8'h90;
  localparam logic [7:0] F4_SEC_MAX  = 8'h8F;

  // one entry of the job queue: cnt results, all but the last are
  // one-byte error steps, the last one is (len, err)
  typedef struct packed {
    logic [2:0] cnt;
    logic [2:0] len;
    logic       err;
  } job_t;

  typedef struct packed {
    logic       ascii;
    logic       bad;
    logic [1:0] need;
  } lead_t;

  function automatic lead_t lead_class(input logic [7:0] b);
    lead_t r;
    r = '0;
    if (b <= ASCII_MAX) begin
      r.ascii = 1'b1;
    end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
      r.need = 2'd3;
    end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
      r.need = 2'd2;
    end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
      r.need = 2'd1;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage

/* rtl/utf8_sequence_segmenter.sv */
// utf8_sequence_segmenter: top level, front classifier, job queue and back expander
// depends on utf8s_pkg, utf8s_front, utf8s_job_queue, utf8s_back
//
// Takes one byte per clock while full is low. Each byte becomes at most one job
// in a queue of JOB_DEPTH entries; the back end turns a job into its 1 to 4
// results at one result per clock while the output is empty or popped, so a byte
// that breaks a sequence holds the back end while it emits its results, and the
// queue absorbs such bursts. full rises only when the job queue is full. A result
// passes through the job queue and then the output register, earlier results
// permitting, and stays on the output ports until it is popped.
module utf8_sequence_segmenter import utf8s_pkg::*; #(
  parameter int unsigned JOB_DEPTH = UTF8S_JOB_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       end_of_text,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] seq_length,
  output logic       seq_error,
  output logic       last_of_run
);

  logic take;
  logic fr_valid;
  job_t fr_job;
  logic q_valid;
  job_t q_head;
  logic q_rd;

  assign take = push & ~full;

  utf8s_front u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .data_byte  (data_byte),
    .end_of_text(end_of_text),
    .job_valid  (fr_valid),
    .job        (fr_job)
  );

  utf8s_job_queue #(
    .DEPTH(JOB_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (take & fr_valid),
    .wr_job(fr_job),
    .rd    (q_rd),
    .full  (full),
    .valid (q_valid),
    .head  (q_head)
  );

  utf8s_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (q_valid),
    .job        (q_head),
    .job_done   (q_rd),
    .empty      (empty),
    .pop        (pop),
    .seq_length (seq_length),
    .seq_error  (seq_error),
    .last_of_run(last_of_run)
  );

endmodule

/* rtl/utf8s_front.sv */
// utf8s_front: sequence state and byte classification, at most one job per byte
// depends on utf8s_pkg
module utf8s_front import utf8s_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       end_of_text,
  output logic       job_valid,
  output job_t       job
);

  logic [7:0] lead_value, lead_value_next;
  logic [1:0] taken, taken_next;
  logic [1:0] still, still_next;
  logic       in_seq, in_seq_next;

  lead_t      lc;
  logic       cont_ok;
  logic       lead_emits;
  logic [2:0] flush_n;

  always_comb begin
    lc = lead_class(data_byte);
    cont_ok = (data_byte >= CONT_MIN) && (data_byte <= CONT_MAX);
    if (taken == 2'd0) begin
      if (lead_value == LEAD_E0 && data_byte < E0_SEC_MIN) cont_ok = 1'b0;
      if (lead_value == LEAD_ED && data_byte > ED_SEC_MAX) cont_ok = 1'b0;
      if (lead_value == LEAD_F0 && data_byte < F0_SEC_MIN) cont_ok = 1'b0;
      if (lead_value == LEAD_F4 && data_byte > F4_SEC_MAX) cont_ok = 1'b0;
    end
    lead_emits = lc.ascii | lc.bad | end_of_text;
    flush_n = {1'b0, taken} + 3'd1;

    lead_value_next = lead_value;
    taken_next = taken;
    still_next = still;
    in_seq_next = in_seq;
    job_valid = 1'b0;
    job = '0;

    if (in_seq && cont_ok) begin
      if (still == 2'd1) begin
        job_valid = 1'b1;
        job.cnt = 3'd1;
        job.len = {1'b0, taken} + 3'd2;
        job.err = 1'b0;
        in_seq_next = 1'b0;
        taken_next = '0;
        still_next = '0;
        lead_value_next = '0;
      end else if (end_of_text) begin
        // lead, earlier continuations and this one
        job_valid = 1'b1;
        job.cnt = {1'b0, taken} + 3'd2;
        job.len = 3'd1;
        job.err = 1'b1;
        in_seq_next = 1'b0;
        taken_next = '0;
        still_next = '0;
        lead_value_next = '0;
      end else begin
        taken_next = taken + 2'd1;
        still_next = still - 2'd1;
      end
    end else begin
      // broken sequence flushes first, then the byte is a new lead
      job_valid = in_seq | lead_emits;
      job.cnt = (in_seq ? flush_n : 3'd0) + {2'b00, lead_emits};
      job.len = 3'd1;
      job.err = lead_emits ? ~lc.ascii : 1'b1;
      if (!lead_emits) begin
        in_seq_next = 1'b1;
        lead_value_next = data_byte;
        taken_next = '0;
        still_next = lc.need;
      end else begin
        in_seq_next = 1'b0;
        lead_value_next = '0;
        taken_next = '0;
        still_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_value <= '0;
      taken <= '0;
      still <= '0;
      in_seq <= 1'b0;
    end else if (take) begin
      lead_value <= lead_value_next;
      taken <= taken_next;
      still <= still_next;
      in_seq <= in_seq_next;
    end
  end

endmodule

/* rtl/utf8s_job_queue.sv */
// utf8s_job_queue: small fifo of jobs between front and back
// depends on utf8s_pkg
module utf8s_job_queue import utf8s_pkg::*; #(
  parameter int unsigned DEPTH = UTF8S_JOB_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  job_t wr_job,
  input  logic rd,
  output logic full,
  output logic valid,
  output job_t head
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          slots [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [CW-1:0] count;
  logic          do_wr, do_rd;

  assign full  = (count == FULL_CNT);
  assign valid = (count != '0);
  assign head  = slots[rp];
  assign do_wr = wr & ~full;
  assign do_rd = rd & valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wp] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wp <= (wp == LAST) ? '0 : wp + AW'(1);
      end
      if (do_rd) begin
        rp <= (rp == LAST) ? '0 : rp + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* rtl/utf8s_back.sv */
// utf8s_back: expands each job into its results in the output register, one per
// cycle while that register is empty or popped; depends on utf8s_pkg
module utf8s_back import utf8s_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_done,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] seq_length,
  output logic       seq_error,
  output logic       last_of_run
);

  logic [1:0] idx;
  logic       out_valid;
  logic       advance;
  logic       is_last;

  assign empty    = ~out_valid;
  assign advance  = job_valid & (~out_valid | pop);
  assign is_last  = ({1'b0, idx} + 3'd1) == job.cnt;
  assign job_done = advance & is_last;

  always_ff @(posedge clk) begin
    if (advance) begin
      seq_length  <= is_last ? job.len : 3'd1;
      seq_error   <= is_last ? job.err : 1'b1;
      last_of_run <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        idx <= is_last ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* test/tb_utf8_sequence_segmenter.sv */
// tb_utf8_sequence_segmenter: self-checking bench for the utf8 sequence segmenter
// holds a step scoreboard class and the push/pop drivers; depends on utf8s_pkg
// and utf8_sequence_segmenter
module tb_utf8_sequence_segmenter import utf8s_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 330;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 80;

  typedef struct packed {
    logic [2:0] len;
    logic       err;
    logic       last;
  } step_t;

  class utf8_step_scoreboard;
    logic [7:0] lead;
    logic [1:0] taken;
    logic [1:0] remaining;
    bit         open;
    step_t      steps_due[$];
    int         errors;
    int         checked;

    function new();
      lead = '0;
      taken = '0;
      remaining = '0;
      open = 1'b0;
      errors = 0;
      checked = 0;
    endfunction

    function void add_step(logic [2:0] len, logic err);
      step_t s;
      s.len = len;
      s.err = err;
      s.last = 1'b0;
      steps_due.push_back(s);
    endfunction

    function void flush_open();
      int i;
      add_step(3'd1, 1'b1);
      for (i = 0; i < taken; i++) add_step(3'd1, 1'b1);
      open = 1'b0;
      taken = '0;
      remaining = '0;
      lead = '0;
    endfunction

    function bit continues(logic [7:0] b);
      if (b < CONT_MIN || b > CONT_MAX) return 1'b0;
      if (taken == 2'd0) begin
        if (lead == LEAD_E0 && b < E0_SEC_MIN) return 1'b0;
        if (lead == LEAD_ED && b > ED_SEC_MAX) return 1'b0;
        if (lead == LEAD_F0 && b < F0_SEC_MIN) return 1'b0;
        if (lead == LEAD_F4 && b > F4_SEC_MAX) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void start_char(logic [7:0] b, logic eot);
      logic [1:0] need;
      if (b <= ASCII_MAX) begin
        add_step(3'd1, 1'b0);
        return;
      end
      if (b >= LEAD4_MIN && b <= LEAD4_MAX) need = 2'd3;
      else if (b >= LEAD3_MIN && b <= LEAD3_MAX) need = 2'd2;
      else if (b >= LEAD2_MIN && b <= LEAD2_MAX) need = 2'd1;
      else begin
        add_step(3'd1, 1'b1);
        return;
      end
      if (eot) begin
        add_step(3'd1, 1'b1);
        return;
      end
      lead = b;
      taken = '0;
      remaining = need;
      open = 1'b1;
    endfunction

    // predicts the steps caused by one transferred byte
    function void segment_byte(logic [7:0] b, logic eot);
      int    before_n;
      step_t s;
      before_n = steps_due.size();
      if (open) begin
        if (continues(b)) begin
          taken = taken + 2'd1;
          remaining = remaining - 2'd1;
          if (remaining == 2'd0) begin
            add_step({1'b0, taken} + 3'd1, 1'b0);
            open = 1'b0;
            taken = '0;
            lead = '0;
          end else if (eot) begin
            flush_open();
          end
        end else begin
          flush_open();
          start_char(b, eot);
        end
      end else begin
        start_char(b, eot);
      end
      if (steps_due.size() > before_n) begin
        s = steps_due.pop_back();
        s.last = 1'b1;
        steps_due.push_back(s);
      end
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_step(logic [2:0] len, logic err, logic last);
      step_t want;
      if (steps_due.size() == 0) begin
        report($sformatf("step len=%0d err=%0d last=%0d with none expected", len, err, last));
        return;
      end
      want = steps_due.pop_front();
      checked++;
      if (len !== want.len)
        report($sformatf("seq_length %0d, expected %0d", len, want.len));
      if (err !== want.err)
        report($sformatf("seq_error %0d, expected %0d", err, want.err));
      if (last !== want.last)
        report($sformatf("last_of_run %0d, expected %0d", last, want.last));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] data_byte = '0;
  logic       end_of_text = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [2:0] seq_length;
  logic       seq_error;
  logic       last_of_run;

  utf8_step_scoreboard board = new();
  bit  idle_on = 1'b1;
  bit  hold_request = 1'b0;
  int  bytes_sent = 0;
  int  stall_cycles = 0;
  int  cycles = 0;

  logic [8:0] directed[$] = '{
    9'h000, 9'h07F, 9'h080, 9'h0C1, 9'h0F5, 9'h0FF,
    9'h0C2, 9'h080, 9'h0E0, 9'h09F, 9'h0ED, 9'h09F, 9'h0BF,
    9'h0F0, 9'h090, 9'h080, 9'h180, 9'h0F4, 9'h090,
    9'h0E1, 9'h180, 9'h0F1, 9'h080, 9'h080, 9'h0FF, 9'h1C2
  };

  utf8_sequence_segmenter uut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .data_byte   (data_byte),
    .end_of_text (end_of_text),
    .empty       (empty),
    .pop         (pop),
    .seq_length  (seq_length),
    .seq_error   (seq_error),
    .last_of_run (last_of_run)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (push && full) stall_cycles++;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d steps still due", cycles, board.steps_due.size());
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic e);
    while (idle_on && $urandom_range(0, 99) < 8) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    data_byte <= b;
    end_of_text <= e;
    @(posedge clk);
    while (full) @(posedge clk);
    board.segment_byte(b, e);
    bytes_sent++;
  endtask

  // mostly well-formed characters, some broken ones and some noise
  task automatic send_sequence();
    logic [7:0] seq[$];
    logic [7:0] lo;
    logic [7:0] hi;
    int         kind;
    int         n;
    int         good;
    int         i;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      seq.push_back(8'($urandom_range(0, ASCII_MAX)));
    end else if (kind < 85) begin
      n = $urandom_range(2, 4);
      case (n)
        2: seq.push_back(8'($urandom_range(LEAD2_MIN, LEAD2_MAX)));
        3: seq.push_back(8'($urandom_range(LEAD3_MIN, LEAD3_MAX)));
        default: seq.push_back(8'($urandom_range(LEAD4_MIN, LEAD4_MAX)));
      endcase
      lo = CONT_MIN;
      hi = CONT_MAX;
      if (seq[0] == LEAD_E0) lo = E0_SEC_MIN;
      if (seq[0] == LEAD_ED) hi = ED_SEC_MAX;
      if (seq[0] == LEAD_F0) lo = F0_SEC_MIN;
      if (seq[0] == LEAD_F4) hi = F4_SEC_MAX;
      good = (kind < 70) ? n - 1 : $urandom_range(0, n - 2);
      for (i = 0; i < good; i++) begin
        if (i == 0) seq.push_back(8'($urandom_range(lo, hi)));
        else seq.push_back(8'($urandom_range(CONT_MIN, CONT_MAX)));
      end
      if (kind >= 70) seq.push_back(8'($urandom_range(0, 255)));
    end else begin
      seq.push_back(8'($urandom_range(0, 255)));
    end
    for (i = 0; i < seq.size(); i++) send_byte(seq[i], $urandom_range(0, 11) == 0);
  endtask

  // result side, with a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (pop && !empty) board.check_step(seq_length, seq_error, last_of_run);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= !(idle_on && $urandom_range(0, 99) < 8);
      end
    end
  end

  initial begin
    int i;
    int random_start;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < directed.size(); i++) send_byte(directed[i][7:0], directed[i][8]);

    hold_request = 1'b1;
    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      idle_on = !(bytes_sent - random_start >= 120 && bytes_sent - random_start < 220);
      send_sequence();
    end
    idle_on = 1'b1;
    push <= 1'b0;

    while (board.steps_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("covered %0d bytes (%0d directed, %0d random), %0d steps checked",
             bytes_sent, directed.size(), bytes_sent - random_start, board.checked);
    $display("input held off by full on %0d cycles", stall_cycles);
    if (board.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* filelist.f */
rtl/utf8s_pkg.sv
rtl/utf8s_front.sv
rtl/utf8s_job_queue.sv
rtl/utf8s_back.sv
rtl/utf8_sequence_segmenter.sv
test/tb_utf8_sequence_segmenter.sv
